>>> design/rtcbm_pkg.sv
// ----------------------------------------------------------------------------
// Three-wire RTC bus master package
// Shared field layouts, request codes and constants for the bus master.
// ----------------------------------------------------------------------------
package rtcbm_pkg;

	localparam int unsigned HALF_W        = 16;
	localparam int unsigned BYTE_CNT_W    = 3;
	localparam int unsigned BURST_BYTES_D = 8;
	localparam logic [HALF_W-1:0] HALF_RESET = 16'd100;

	// Command byte for a clock burst read. The read bit is added when it is sent.
	localparam logic [7:0] BURST_CMD = 8'hBE;
	localparam logic [7:0] READ_BIT  = 8'h01;

	typedef enum logic [1:0] {
		FUNC_NONE  = 2'd0,
		FUNC_WRITE = 2'd1,
		FUNC_READ  = 2'd2,
		FUNC_BURST = 2'd3
	} func_t;

	typedef struct packed {
		logic       io_pin_in;
		logic [7:0] write_data;
		logic [7:0] command_byte;
		func_t      func;
	} item_t;

	typedef struct packed {
		logic                  done_res;
		logic [BYTE_CNT_W-1:0] byte_number;
		logic                  read_valid;
		logic [7:0]            read_byte;
		logic                  busy_res;
		logic                  io_pin_out;
		logic                  io_drive_enable;
		logic                  serial_clock;
		logic                  chip_enable;
	} result_t;

endpackage

>>> design/rtcbm_engine.sv
// ----------------------------------------------------------------------------
// Three-wire RTC bus master engine
// Holds the bus state and advances it by one tick per stepped item.
// ----------------------------------------------------------------------------
module rtcbm_engine
	import rtcbm_pkg::*;
#(
	parameter int unsigned BURST_BYTES = BURST_BYTES_D
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,
	input  item_t             item,
	input  logic [HALF_W-1:0] half_period_ticks,
	output result_t           result
);

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_CMD   = 3'd1,
		PH_WDATA = 3'd2,
		PH_READ  = 3'd3,
		PH_TAIL  = 3'd4
	} phase_t;

	localparam logic [BYTE_CNT_W:0] LAST_BYTES = (BYTE_CNT_W+1)'(BURST_BYTES);

	phase_t                phase_q, phase_n;
	func_t                 kind_q, kind_n;
	logic [7:0]            shift_q, shift_n;
	logic [7:0]            hold_q, hold_n;
	logic [2:0]            bit_q, bit_n;
	logic [BYTE_CNT_W-1:0] byte_q, byte_n;
	logic [HALF_W-1:0]     tick_q, tick_n;
	logic                  sclk_q, sclk_n;
	logic                  drv_en_q, drv_en_n;
	logic                  drv_lvl_q, drv_lvl_n;

	logic [HALF_W-1:0]     half;
	logic [HALF_W-1:0]     tick_inc;
	logic [BYTE_CNT_W:0]   byte_inc;
	logic                  valid;
	logic [7:0]            rbyte;
	logic [BYTE_CNT_W-1:0] rnum;
	logic                  done;

	always_comb begin
		half     = (half_period_ticks == '0) ? HALF_W'(1) : half_period_ticks;
		tick_inc = tick_q + HALF_W'(1);
		byte_inc = {1'b0, byte_q} + (BYTE_CNT_W+1)'(1);

		phase_n   = phase_q;
		kind_n    = kind_q;
		shift_n   = shift_q;
		hold_n    = hold_q;
		bit_n     = bit_q;
		byte_n    = byte_q;
		tick_n    = tick_q;
		sclk_n    = sclk_q;
		drv_en_n  = drv_en_q;
		drv_lvl_n = drv_lvl_q;
		valid     = 1'b0;
		rbyte     = '0;
		rnum      = '0;
		done      = 1'b0;

		if (phase_q == PH_IDLE) begin
			if (item.func != FUNC_NONE) begin
				kind_n = item.func;
				unique case (item.func)
					FUNC_WRITE: shift_n = item.command_byte;
					FUNC_READ:  shift_n = item.command_byte | READ_BIT;
					default:    shift_n = BURST_CMD | READ_BIT;
				endcase
				hold_n    = item.write_data;
				bit_n     = '0;
				byte_n    = '0;
				tick_n    = '0;
				sclk_n    = 1'b0;
				drv_en_n  = 1'b1;
				drv_lvl_n = shift_n[0];
				phase_n   = PH_CMD;
			end
		end else begin
			tick_n = tick_inc;
			if (tick_inc >= half) begin
				tick_n = '0;
				unique case (phase_q)
					PH_CMD, PH_WDATA: begin
						if (!sclk_q) begin
							sclk_n = 1'b1;
						end else begin
							sclk_n = 1'b0;
							if (bit_q == 3'd7) begin
								bit_n = '0;
								if (phase_q == PH_WDATA) begin
									phase_n = PH_IDLE;
									done    = 1'b1;
								end else if (kind_q == FUNC_WRITE) begin
									phase_n   = PH_WDATA;
									shift_n   = hold_q;
									drv_lvl_n = hold_q[0];
								end else begin
									phase_n  = PH_READ;
									drv_en_n = 1'b0;
									shift_n  = '0;
									byte_n   = '0;
								end
							end else begin
								bit_n     = bit_q + 3'd1;
								shift_n   = shift_q >> 1;
								drv_lvl_n = shift_q[1];
							end
						end
					end
					PH_READ: begin
						if (!sclk_q) begin
							shift_n         = shift_q;
							shift_n[bit_q]  = shift_q[bit_q] | item.io_pin_in;
							sclk_n          = 1'b1;
							if (bit_q == 3'd7) begin
								valid = 1'b1;
								rbyte = shift_n;
								rnum  = byte_q;
							end
						end else begin
							sclk_n = 1'b0;
							if (bit_q == 3'd7) begin
								bit_n = '0;
								if (kind_q != FUNC_BURST || byte_inc >= LAST_BYTES) begin
									phase_n = PH_TAIL;
								end else begin
									byte_n  = byte_inc[BYTE_CNT_W-1:0];
									shift_n = '0;
								end
							end else begin
								bit_n = bit_q + 3'd1;
							end
						end
					end
					default: begin
						phase_n = PH_IDLE;
						done    = 1'b1;
						if (kind_q == FUNC_BURST) begin
							drv_en_n  = 1'b1;
							drv_lvl_n = 1'b1;
						end
					end
				endcase
			end
		end

		result.chip_enable     = (phase_n != PH_IDLE);
		result.serial_clock    = sclk_n;
		result.io_drive_enable = drv_en_n;
		result.io_pin_out      = drv_en_n & drv_lvl_n;
		result.busy_res        = (phase_n != PH_IDLE);
		result.read_byte       = rbyte;
		result.read_valid      = valid;
		result.byte_number     = rnum;
		result.done_res        = done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			kind_q    <= FUNC_NONE;
			shift_q   <= '0;
			hold_q    <= '0;
			bit_q     <= '0;
			byte_q    <= '0;
			tick_q    <= '0;
			sclk_q    <= 1'b0;
			drv_en_q  <= 1'b1;
			drv_lvl_q <= 1'b1;
		end else if (step_en) begin
			phase_q   <= phase_n;
			kind_q    <= kind_n;
			shift_q   <= shift_n;
			hold_q    <= hold_n;
			bit_q     <= bit_n;
			byte_q    <= byte_n;
			tick_q    <= tick_n;
			sclk_q    <= sclk_n;
			drv_en_q  <= drv_en_n;
			drv_lvl_q <= drv_lvl_n;
		end
	end

endmodule

>>> design/three_wire_rtc_bus_master_core.sv
// ----------------------------------------------------------------------------
// Three-wire RTC bus master core
// Tick-driven master for a three-wire (CE, SCLK, IO) real-time-clock bus.
// ----------------------------------------------------------------------------
// Every input transaction is one bus tick: it carries the sampled IO level and,
// while the master is idle, an optional request (single write, single read or
// clock burst read). Every input transaction yields exactly one output
// transaction with the pin levels for that tick plus any read byte completed.
// The core takes one transaction per clock cycle when the output side keeps up:
// an input register feeds a single pass of the tick logic, whose result lands in
// an output register, from which the output side takes each result. Only a
// stalled output side slows the input down. A new input is taken while a result
// still waits in the output register, as long as the input register can move
// forward. The half period in ticks between SCLK edges is set through
// cfg_we/cfg_wdata (reset 100, zero acts as one) and should be written only
// while no transaction is in flight.
// ----------------------------------------------------------------------------
module three_wire_rtc_bus_master_core
	import rtcbm_pkg::*;
#(
	parameter int unsigned BURST_BYTES = BURST_BYTES_D
) (
	input  logic              clk,
	input  logic              arst_n,
	// Configuration: half period in ticks.
	input  logic              cfg_we,
	input  logic [HALF_W-1:0] cfg_wdata,
	// Input stream.
	input  logic              s_tvalid,
	output logic              s_tready,
	// s_tdata: command_byte[7:0], write_data[15:8], io_pin_in[16], zero pad [23:17].
	input  logic [23:0]       s_tdata,
	// s_tuser: func[1:0].
	input  logic [1:0]        s_tuser,
	// Output stream.
	output logic              m_tvalid,
	input  logic              m_tready,
	// m_tdata: chip_enable[0], serial_clock[1], io_drive_enable[2], io_pin_out[3],
	// busy_res[4], read_byte[12:5], byte_number[15:13], done_res[16], zero pad [23:17].
	output logic [23:0]       m_tdata,
	// m_tuser: read_valid[0].
	output logic              m_tuser
);

	logic [HALF_W-1:0] half_q;
	item_t             item_s1;
	logic              valid_s1;
	result_t           step_res;
	result_t           res_s2;
	logic              valid_s2;
	logic              advance;
	logic              take_in;

	// The stage-one transaction moves into the tick logic when the output
	// register is empty or is being drained in this cycle.
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign take_in  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= HALF_RESET;
		end else if (cfg_we) begin
			half_q <= cfg_wdata;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1.func         <= func_t'(s_tuser);
			item_s1.command_byte <= s_tdata[7:0];
			item_s1.write_data   <= s_tdata[15:8];
			item_s1.io_pin_in    <= s_tdata[16];
		end
	end

	// Bus state and the per-tick logic; state advances once per transaction.
	rtcbm_engine #(
		.BURST_BYTES(BURST_BYTES)
	) u_engine (
		.clk              (clk),
		.arst_n           (arst_n),
		.step_en          (advance),
		.item             (item_s1),
		.half_period_ticks(half_q),
		.result           (step_res)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= step_res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.read_valid;
	assign m_tdata  = {7'd0, res_s2.done_res, res_s2.byte_number, res_s2.read_byte,
		res_s2.busy_res, res_s2.io_pin_out, res_s2.io_drive_enable,
		res_s2.serial_clock, res_s2.chip_enable};

endmodule
